[hw/rtl/signed_int_to_decimal_ascii_macros.svh]
// Assertion macros shared by the signed integer to decimal text block
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTH

// Check that a condition holds at every clock edge out of reset
`define SITDA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define SITDA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`else

`define SITDA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define SITDA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg)

`endif

`endif

[hw/rtl/sitda_pkg.sv]
// Shared types, constants and helpers for the decimal text converter
package sitda_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Decimal digits needed for a magnitude of up to 2**(w-1)
  function automatic int num_digits(input int w);
    return ((w - 1) * 30103) / 100000 + 1;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } sitda_state_e;

  // Status of the binary to BCD converter
  typedef struct packed {
    logic busy;
    logic done;
  } sitda_conv_st_t;

  // Control from the sequencer to the character emitter
  typedef struct packed {
    logic load;
    logic neg;
  } sitda_emit_ctl_t;

endpackage

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text, one character per transfer
//
// Input channel: in_valid_i / in_stall_o carry one signed VALUE_WIDTH-bit
// integer per transfer. Output channel: out_valid_o / out_stall_i carry one
// ASCII character per transfer, most significant first, with a leading '-'
// for negative values and last_char_o set on the final character.
// One number is in flight at a time; in_stall_o stays high from the
// transfer until its last character has been taken.
// The number is converted by shift-and-add-3, one magnitude bit per cycle
// in the BCD shift register, and the result is then handed over to the
// emitter, which drops the leading zeros and offers the characters.
// A stall on the output holds the current character and pauses the
// emitter; nothing is lost or repeated.
// Reset empties the converter, the emitter and the output register; the
// block takes a new number in the first cycle after reset.
`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             ascii_char_o,
  output logic                   last_char_o
);

  localparam int BcdW = 4 * num_digits(VALUE_WIDTH);

  sitda_state_e           state_q, state_d;
  logic                   neg_q, neg_d;
  logic                   in_xfer;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BcdW-1:0]        bcd;
  sitda_conv_st_t         conv_st;
  sitda_emit_ctl_t        emit_ctl;
  logic                   emit_busy;
  logic                   conv_start;

  assign in_xfer = in_valid_i && !in_stall_o;

  // Magnitude of the input; the most negative value maps onto itself,
  // which read as unsigned is the right magnitude.
  assign mag = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_CONV;
      ST_CONV: if (conv_st.done) state_d = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall_o    = 1'b1;
    conv_start    = 1'b0;
    emit_ctl.load = 1'b0;
    emit_ctl.neg  = neg_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        conv_start = in_valid_i;
      end
      ST_CONV: emit_ctl.load = conv_st.done;
      ST_EMIT: in_stall_o = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

  // Hold the sign until the emitter is loaded
  assign neg_d = in_xfer ? value_i[VALUE_WIDTH-1] : neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
  end

  sitda_dabble #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .mag_i   (mag),
    .bcd_o   (bcd),
    .status_o(conv_st)
  );

  sitda_emit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (emit_ctl),
    .bcd_i       (bcd),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_o(ascii_char_o),
    .last_char_o (last_char_o)
  );

  // Characters only leave while the emitter owns the number
  `SITDA_ASSERT_ALWAYS(a_out_in_emit, clk_i, rst_ni, !out_valid_o || state_q == ST_EMIT, "output valid outside emit phase")
  // A new number never lands on a running conversion
  `SITDA_ASSERT_ALWAYS(a_no_xfer_busy, clk_i, rst_ni, !in_xfer || !conv_st.busy, "input transfer during conversion")
  // After the last character is taken nothing further is offered
  `SITDA_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_valid_o && !out_stall_i && last_char_o, !out_valid_o, "character offered after last")

endmodule

[hw/rtl/sitda_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3, one bit per cycle)
module sitda_dabble import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [VALUE_WIDTH-1:0]                 mag_i,
  output logic [4*num_digits(VALUE_WIDTH)-1:0]   bcd_o,
  output sitda_conv_st_t                         status_o
);

  localparam int NumDigits = num_digits(VALUE_WIDTH);
  localparam int BcdW      = 4 * NumDigits;
  localparam int CntW      = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BcdW-1:0]        bcd_q, bcd_d;
  logic [BcdW-1:0]        adj;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   done_q, done_d;

  // Add three to every digit of five or more ahead of the shift
  always_comb begin
    logic [3:0] dgt;
    for (int i = 0; i < NumDigits; i++) begin
      dgt = bcd_q[i*4 +: 4];
      adj[i*4 +: 4] = (dgt >= 4'd5) ? dgt + 4'd3 : dgt;
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d = mag_i;
      bcd_d = '0;
      cnt_d = CntW'(VALUE_WIDTH);
    end else if (cnt_q != '0) begin
      bcd_d  = {adj[BcdW-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d  = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o         = bcd_q;
  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;

endmodule

[hw/rtl/sitda_emit.sv]
// Character emitter: sign, leading-zero drop and digit output register
module sitda_emit import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sitda_emit_ctl_t                      ctl_i,
  input  logic [4*num_digits(VALUE_WIDTH)-1:0] bcd_i,
  output logic                                 busy_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           ascii_char_o,
  output logic                                 last_char_o
);

  localparam int NumDigits = num_digits(VALUE_WIDTH);
  localparam int BcdW      = 4 * NumDigits;
  localparam int RemW      = $clog2(NumDigits + 1);

  logic [BcdW-1:0] dig_q, dig_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic            sign_q, sign_d;
  logic            lead_q, lead_d;
  logic            vld_q, vld_d;
  logic [7:0]      char_q, char_d;
  logic            last_q, last_d;
  logic            slot_free;
  logic [3:0]      top_dig;

  assign slot_free = !vld_q || !out_stall_i;
  assign top_dig   = dig_q[BcdW-1 -: 4];

  always_comb begin
    dig_d  = dig_q;
    rem_d  = rem_q;
    sign_d = sign_q;
    lead_d = lead_q;
    vld_d  = vld_q && out_stall_i;
    char_d = char_q;
    last_d = last_q;
    if (ctl_i.load) begin
      dig_d  = bcd_i;
      rem_d  = RemW'(NumDigits);
      sign_d = ctl_i.neg;
      lead_d = 1'b1;
    end else if (rem_q != '0 && slot_free) begin
      if (sign_q) begin
        vld_d  = 1'b1;
        char_d = CHAR_MINUS;
        last_d = 1'b0;
        sign_d = 1'b0;
      end else if (lead_q && top_dig == 4'd0 && rem_q != RemW'(1)) begin
        // drop a leading zero
        dig_d = {dig_q[BcdW-5:0], 4'h0};
        rem_d = rem_q - RemW'(1);
      end else begin
        vld_d  = 1'b1;
        char_d = CHAR_ZERO + {4'h0, top_dig};
        last_d = (rem_q == RemW'(1));
        dig_d  = {dig_q[BcdW-5:0], 4'h0};
        rem_d  = rem_q - RemW'(1);
        lead_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      sign_q <= 1'b0;
      lead_q <= 1'b0;
      vld_q  <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      sign_q <= sign_d;
      lead_q <= lead_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o       = (rem_q != '0) || vld_q;
  assign out_valid_o  = vld_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

[tb/sv/sitda_text_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts the decimal text of each number and compares it with the character stream
module sitda_text_checker import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [7:0]             ascii_char_i,
  input  logic                   last_char_i,
  output int                     fail_count_o,
  output int                     due_count_o,
  output int                     numbers_o,
  output int                     negatives_o,
  output int                     chars_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } text_char_t;

  // Characters still owed by the block, oldest first
  text_char_t due_chars [$];

  int fails;
  int numbers;
  int negatives;
  int chars;

  // Append the decimal text of one number to the characters owed
  function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] value);
    logic [63:0] span_mask;
    logic [63:0] mag;
    logic [7:0]  digit_buf [0:19];
    int          nd;
    span_mask = (64'd1 << VALUE_WIDTH) - 64'd1;
    mag = 64'(value);
    // Form the magnitude in 64 bits, so the most negative value needs no care
    if (value[VALUE_WIDTH-1]) mag = (~mag + 64'd1) & span_mask;
    nd = 0;
    do begin
      digit_buf[nd] = CHAR_ZERO + 8'(mag % 64'd10);
      nd++;
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (value[VALUE_WIDTH-1]) due_chars.push_back('{ch: CHAR_MINUS, is_last: 1'b0});
    for (int k = nd - 1; k >= 0; k--) begin
      due_chars.push_back('{ch: digit_buf[k], is_last: (k == 0)});
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        chars++;
        if (due_chars.size() == 0) begin
          fails++;
          $error("ascii_char transfer %0d with no character due", ascii_char_i);
        end else begin
          want = due_chars.pop_front();
          if (ascii_char_i !== want.ch) begin
            fails++;
            $error("ascii_char mismatch: expected %0d, actual %0d", want.ch, ascii_char_i);
          end
          if (last_char_i !== want.is_last) begin
            fails++;
            $error("last_char mismatch: expected %0b, actual %0b", want.is_last, last_char_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        numbers++;
        if (value_i[VALUE_WIDTH-1]) negatives++;
        queue_decimal_text(value_i);
      end
    end
    fail_count_o <= fails;
    due_count_o  <= due_chars.size();
    numbers_o    <= numbers;
    negatives_o  <= negatives;
    chars_o      <= chars;
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for the signed integer to decimal text block: stimulus and verdict
module tb;
  import sitda_pkg::*;

  localparam int VW           = VALUE_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 396;
  // Margin on top of the time the block takes for one number
  localparam int SETTLE_CYCLES = 80;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [VW-1:0] value_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [7:0]    ascii_char_o;
  logic          last_char_o;

  int fail_count;
  int due_count;
  int numbers;
  int negatives;
  int chars;

  // When set, neither side idles: gives stretches of back-to-back traffic
  logic calm;
  int   stall_left;
  int   stall_draw;

  // Hand-picked numbers: zero, single digits, decade boundaries, both extremes
  // and their neighbours, alternating bit patterns
  logic [VW-1:0] directed_vals [$] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd9, 32'd10, -32'sd10, 32'd99,
    32'd100, 32'd101, -32'sd909, 32'd7, 32'd1000000000, 32'd999999999,
    -32'sd999999999, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd123456789, -32'sd123456789
  };

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_o(ascii_char_o),
    .last_char_o (last_char_o)
  );

  sitda_text_checker #(
    .VALUE_WIDTH(VW)
  ) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .ascii_char_i(ascii_char_o),
    .last_char_i (last_char_o),
    .fail_count_o(fail_count),
    .due_count_o (due_count),
    .numbers_o   (numbers),
    .negatives_o (negatives),
    .chars_o     (chars)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random number, shaped so that every text length and both signs turn up
  // often, rather than the ten-digit values a flat draw mostly gives
  function automatic logic [VW-1:0] random_value();
    logic [63:0] mag;
    logic [63:0] lo;
    logic [63:0] span;
    logic [63:0] ceiling;
    int          d;
    logic        neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6: begin
        // Uniform over the numbers with d digits, capped at the range limit
        d  = $urandom_range(1, 10);
        lo = 64'd1;
        repeat (d - 1) lo = lo * 64'd10;
        span = lo * 64'd9;
        if (d == 1) begin
          lo   = 64'd0;
          span = 64'd10;
        end
        ceiling = neg ? 64'd2147483648 : 64'd2147483647;
        if (lo + span - 64'd1 > ceiling) span = ceiling - lo + 64'd1;
        mag = lo + {$urandom(), $urandom()} % span;
      end
      7: mag = 64'($urandom_range(0, 20));
      8: return neg ? 32'h8000_0000 + $urandom_range(0, 3)
                    : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: begin
        // A power of ten or one either side of it
        mag = 64'd1;
        repeat ($urandom_range(0, 9)) mag = mag * 64'd10;
        mag = mag + 64'($urandom_range(0, 2)) - 64'd1;
      end
    endcase
    return neg ? VW'(-mag) : VW'(mag);
  endfunction

  // Offer one number after a random gap and hold it until the transfer
  task automatic send_number(input logic [VW-1:0] v);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and hold off until every character owed has been taken
  task automatic drain_text();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (due_count == 0);
    @(posedge clk_i);
  endtask

  // Receiver: alternate stalled and free runs of random length, never
  // stalling while calm is set
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_left  <= pick_gap();
    end else begin
      stall_draw = pick_gap();
      if (stall_draw != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_draw - 1;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    value_i     <= '0;
    calm        <= 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed numbers: the first half back to back, then with idling
    foreach (directed_vals[i]) begin
      if (i == 12) calm <= 1'b0;
      send_number(directed_vals[i]);
    end
    drain_text();

    // Random numbers, with a calm stretch in the middle and periodic
    // pauses until the text of everything sent so far has come out
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 180) calm <= 1'b1;
      if (n == 240) calm <= 1'b0;
      if (n % 70 == 69) drain_text();
      send_number(random_value());
    end
    in_valid_i <= 1'b0;

    // Wait for the last characters, then give any stray transfer time to show
    @(posedge clk_i);
    wait (due_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d negative) into %0d characters,",
             numbers, negatives, chars);
    $display("covering every text length, both extremes and idling on both sides.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest run, every character fully stalled
  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
